[hw/rtl/xbr_pkg.sv]
// ----------------------------------------------------------------------------
// XMODEM block receiver package
// Shared types and constants for the byte-serial XMODEM checksum receiver.
// ----------------------------------------------------------------------------
package xbr_pkg;

  // Fixed frame geometry of the checksum variant of the protocol.
  localparam int unsigned PayloadLen = 128;
  localparam int unsigned IdxBits    = $clog2(PayloadLen);

  localparam logic [7:0]  ByteSoh     = 8'h01;
  localparam logic [7:0]  ByteEot     = 8'h04;
  localparam logic [8:0]  ComplTarget = 9'h0FF;
  localparam logic [16:0] CountMax    = 17'h1FFFF;
  localparam logic [16:0] AreaReset   = 17'h10000;

  typedef enum logic [2:0] {
    KindWrite   = 3'd0,
    KindAck     = 3'd1,
    KindNak     = 3'd2,
    KindEnd     = 3'd3,
    KindDiscard = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    PhIdle  = 5'b00001,
    PhBlock = 5'b00010,
    PhCompl = 5'b00100,
    PhData  = 5'b01000,
    PhCheck = 5'b10000
  } phase_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [15:0] offset;
    logic [7:0]  data;
    logic [16:0] total;
  } result_t;

endpackage

[hw/rtl/xbr_byte_if.sv]
// ----------------------------------------------------------------------------
// Line byte channel
// Valid/ready channel that carries one received serial line byte.
// ----------------------------------------------------------------------------
interface xbr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink   (input valid, input line_byte, output ready);
endinterface

[hw/rtl/xbr_result_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one receiver result.
// ----------------------------------------------------------------------------
interface xbr_result_if;
  logic            valid;
  logic            ready;
  xbr_pkg::kind_e  result_kind;
  logic [15:0]     write_offset;
  logic [7:0]      write_byte;
  logic [16:0]     session_total;

  modport source (output valid, output result_kind, output write_offset,
                  output write_byte, output session_total, input ready);
  modport sink   (input valid, input result_kind, input write_offset,
                  input write_byte, input session_total, output ready);
endinterface

[hw/rtl/xbr_frame.sv]
// ----------------------------------------------------------------------------
// XMODEM frame tracker
// Holds the frame state and decodes each accepted byte into at most one result.
// ----------------------------------------------------------------------------
module xbr_frame #(
  parameter int unsigned AREA_ADDR_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       line_byte_i,
  input  logic [16:0]      area_size_i,
  output xbr_pkg::result_t result_o
);
  import xbr_pkg::*;

  // Offsets wrap at the area address width and never exceed 16 bits.
  localparam logic [15:0] OffMask = (AREA_ADDR_BITS >= 16) ? 16'hFFFF :
                                    16'((32'd1 << AREA_ADDR_BITS) - 32'd1);

  phase_e              phase_q, phase_d;
  logic [IdxBits-1:0]  idx_q, idx_d;
  logic [7:0]          blk_q, blk_d;
  logic [7:0]          cmp_q, cmp_d;
  logic [7:0]          sum_q, sum_d;
  logic [16:0]         count_q, count_d;
  logic [16:0]         off_sum;
  logic [16:0]         count_sat;

  assign off_sum   = count_q + 17'(idx_q);
  assign count_sat = (count_q > CountMax - 17'(PayloadLen)) ? CountMax
                                                            : count_q + 17'(PayloadLen);

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    blk_d    = blk_q;
    cmp_d    = cmp_q;
    sum_d    = sum_q;
    count_d  = count_q;
    result_o = '0;
    if (accept_i) begin
      unique case (phase_q)
        PhIdle: begin
          priority if (line_byte_i == ByteEot) begin
            count_d        = '0;
            result_o.valid = 1'b1;
            result_o.kind  = KindEnd;
            result_o.total = count_q;
          end else if (line_byte_i == ByteSoh) begin
            phase_d = PhBlock;
            sum_d   = '0;
          end else begin
            result_o.valid = 1'b1;
            result_o.kind  = KindDiscard;
          end
        end
        PhBlock: begin
          blk_d   = line_byte_i;
          phase_d = PhCompl;
        end
        PhCompl: begin
          cmp_d   = line_byte_i;
          idx_d   = '0;
          phase_d = PhData;
        end
        PhData: begin
          sum_d           = sum_q + line_byte_i;
          idx_d           = idx_q + 1'b1;
          result_o.valid  = 1'b1;
          result_o.kind   = KindWrite;
          result_o.offset = off_sum[15:0] & OffMask;
          result_o.data   = line_byte_i;
          if (idx_q == IdxBits'(PayloadLen - 1)) begin
            phase_d = PhCheck;
          end
        end
        PhCheck: begin
          phase_d        = PhIdle;
          result_o.valid = 1'b1;
          result_o.kind  = KindNak;
          if ((({1'b0, blk_q} + {1'b0, cmp_q}) == ComplTarget) &&
              (sum_q == line_byte_i)) begin
            count_d = count_sat;
            if (count_sat < area_size_i) begin
              result_o.kind = KindAck;
            end
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      idx_q   <= '0;
      blk_q   <= '0;
      cmp_q   <= '0;
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      blk_q   <= blk_d;
      cmp_q   <= cmp_d;
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

endmodule

[hw/rtl/xmodem_block_receiver_top.sv]
// ----------------------------------------------------------------------------
// XMODEM block receiver
// Byte-serial XMODEM receiver for 128-byte blocks with an 8-bit sum checksum.
// ----------------------------------------------------------------------------
// The receiver takes one line byte per clock cycle when not stalled and produces at most
// one result per byte in the next cycle, through a single output register. A byte
// is taken in every cycle in which the output register is empty or its
// result is being taken in the same cycle, so a sink that is always ready
// sees a sustained rate of one byte per cycle; the only thing that stalls
// the line side is back pressure on the result channel. Between frames an
// EOT byte ends the session and reports the accepted byte count as the
// session total, SOH opens a frame and any other byte is reported as
// discarded. Inside a frame every payload byte is reported as a tentative
// write at the committed offset plus its index, and the checksum byte is
// answered with ACK or NAK. A NAK is given for a bad complement, a bad
// checksum, or a good block that brings the count to the area size or
// beyond; only good blocks advance the committed count. The area size
// register must be written only while the receiver is idle.
// ----------------------------------------------------------------------------
module xmodem_block_receiver_top #(
  parameter int unsigned AREA_ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_data_i,
  xbr_byte_if.sink    line_i,
  xbr_result_if.source result_o
);
  import xbr_pkg::*;

  logic        accept;
  logic [16:0] area_size_q;
  result_t     frame_res;
  logic        res_valid_q, res_valid_d;
  result_t     res_data_q;

  // The output register frees up in the same cycle its transaction completes.
  assign line_i.ready = !res_valid_q || result_o.ready;
  assign accept       = line_i.valid && line_i.ready;

  // Area size register; blocks are refused once the count reaches it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_size_q <= AreaReset;
    end else if (cfg_we_i) begin
      area_size_q <= cfg_data_i;
    end
  end

  xbr_frame #(
    .AREA_ADDR_BITS (AREA_ADDR_BITS)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .line_byte_i (line_i.line_byte),
    .area_size_i (area_size_q),
    .result_o    (frame_res)
  );

  // A new result overrides the clear, since it can only load when the
  // register is empty or being emptied.
  always_comb begin
    res_valid_d = res_valid_q;
    if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
    if (accept && frame_res.valid) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload needs no reset; it is only looked at while valid.
  always_ff @(posedge clk_i) begin
    if (accept && frame_res.valid) begin
      res_data_q <= frame_res;
    end
  end

  assign result_o.valid         = res_valid_q;
  assign result_o.result_kind   = res_data_q.kind;
  assign result_o.write_offset  = res_data_q.offset;
  assign result_o.write_byte    = res_data_q.data;
  assign result_o.session_total = res_data_q.total;

endmodule

[hw/rtl/xbr_checker.sv]
// ----------------------------------------------------------------------------
// XMODEM block receiver checker
// Port-level assertions on the receiver, attached to the top level by bind.
// ----------------------------------------------------------------------------
module xbr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input xbr_pkg::kind_e out_kind_i,
  input logic [15:0]    out_offset_i,
  input logic [7:0]     out_byte_i,
  input logic [16:0]    out_total_i
);
  import xbr_pkg::*;

  // A stalled result holds its payload until the transaction completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
      $stable(out_offset_i) && $stable(out_byte_i) && $stable(out_total_i))
    else $error("stalled result changed");

  // The line side is held off only by a full, stalled output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("line byte refused without back pressure");

  // Offset and byte are zero outside payload writes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != KindWrite) |-> (out_offset_i == '0) && (out_byte_i == '0))
    else $error("write fields set on a non-write result");

  // The session total is zero outside end of transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i != KindEnd) |-> (out_total_i == '0))
    else $error("session total set on a result other than end of transfer");

endmodule

bind xmodem_block_receiver_top xbr_checker u_xbr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (line_i.valid),
  .in_ready_i   (line_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_kind_i   (result_o.result_kind),
  .out_offset_i (result_o.write_offset),
  .out_byte_i   (result_o.write_byte),
  .out_total_i  (result_o.session_total)
);

[tb/xmodem_block_receiver_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// XMODEM block receiver testbench
// Drives line bytes into the receiver, predicts every result from a local
// copy of the receiver state, and checks each result transaction in order.
// ----------------------------------------------------------------------------
module xmodem_block_receiver_top_tb;
  import xbr_pkg::*;

  localparam int unsigned AreaAddrBits = 16;
  localparam int unsigned DirRows      = 11;

  // One result as the receiver reports it. Fields that a kind does not use
  // are zero.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] offset;
    logic [7:0]  data;
    logic [16:0] total;
  } rx_result_t;

  typedef enum logic {
    RowByte,
    RowFrame
  } row_kind_e;

  // A directed row is either a lone line byte or a whole frame. For a frame,
  // payload byte i is base + i * step, and sum_err is added to the correct
  // checksum. Where typed is set, the result of the last byte of the row is
  // the one written in the row rather than the predicted one.
  typedef struct {
    row_kind_e   kind;
    logic [7:0]  lead;
    logic [7:0]  cpl;
    logic [7:0]  base;
    logic [7:0]  step;
    logic [7:0]  sum_err;
    bit          typed;
    kind_e       exp_kind;
    logic [16:0] exp_total;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [16:0] cfg_data_i;

  xbr_byte_if   line_if ();
  xbr_result_if res_if ();

  xmodem_block_receiver_top #(
    .AREA_ADDR_BITS(AreaAddrBits)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .line_i    (line_if),
    .result_o  (res_if)
  );

  // Local copy of the receiver state, advanced once per accepted line byte.
  int unsigned frame_pos;
  logic [7:0]  frame_blk;
  logic [7:0]  frame_cpl;
  logic [7:0]  frame_sum;
  logic [16:0] accepted_bytes;
  logic [16:0] saved_total;
  logic [16:0] area_bytes;

  rx_result_t  awaited_results [$];
  int unsigned mismatch_count;
  int unsigned line_bytes_sent;

  // Percentage of cycles in which the sender holds back and the result sink
  // stalls. It is zero for one long stretch of the run.
  int unsigned idle_pct;

  // Directed rows. The typed expectations follow directly from the protocol:
  // the first end of transfer after reset reports zero, every good block
  // adds 128 bytes, and a bad complement or checksum is answered with NAK.
  dir_row_t dir_table [DirRows] = '{
    '{RowByte,  8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KindEnd,     17'd0},
    '{RowByte,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KindDiscard, 17'd0},
    '{RowByte,  8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KindDiscard, 17'd0},
    '{RowByte,  8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, KindDiscard, 17'd0},
    // Counting payload that passes through the SOH and EOT values.
    '{RowFrame, 8'h01, 8'hFE, 8'h00, 8'h01, 8'h00, 1'b1, KindAck,     17'd0},
    // Block and complement both 0xFF add to 0x1FE, which is not a match.
    '{RowFrame, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 1'b1, KindNak,     17'd0},
    '{RowFrame, 8'h06, 8'hF9, 8'h33, 8'h05, 8'h01, 1'b1, KindNak,     17'd0},
    '{RowByte,  8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KindEnd,     17'd128},
    '{RowByte,  8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KindEnd,     17'd0},
    '{RowByte,  8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, KindDiscard, 17'd0},
    '{RowByte,  8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, KindDiscard, 17'd0}
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on the run, which leaves a wide margin over the slowest correct run.
  initial begin
    #4_000_000;
    $display("xmodem_block_receiver_top_tb failed");
    $finish;
  end

  // Works out the result that one accepted line byte causes and advances the
  // local state. Returns 1 when the byte causes a result.
  function automatic bit receiver_next_result(input logic [7:0] b,
                                              output rx_result_t r);
    int unsigned offset_full;
    r = '0;
    if (frame_pos == 0) begin
      if (b == ByteEot) begin
        saved_total    = accepted_bytes;
        accepted_bytes = '0;
        r.kind  = KindEnd;
        r.total = saved_total;
        return 1'b1;
      end
      if (b == ByteSoh) begin
        frame_pos = 1;
        frame_sum = 8'h00;
        return 1'b0;
      end
      r.kind = KindDiscard;
      return 1'b1;
    end
    if (frame_pos == 1) begin
      frame_blk = b;
      frame_pos = 2;
      return 1'b0;
    end
    if (frame_pos == 2) begin
      frame_cpl = b;
      frame_pos = 3;
      return 1'b0;
    end
    if (frame_pos < PayloadLen + 3) begin
      // The write lands at the committed count plus the payload index,
      // wrapped to the address width of the area.
      offset_full = (int'(accepted_bytes) + frame_pos - 3) & ((1 << AreaAddrBits) - 1);
      frame_sum   = frame_sum + b;
      frame_pos++;
      r.kind   = KindWrite;
      r.offset = offset_full[15:0];
      r.data   = b;
      return 1'b1;
    end
    // Checksum byte: only a block with a good complement and checksum is
    // committed, and the count saturates instead of wrapping.
    frame_pos = 0;
    r.kind    = KindNak;
    if ((9'(frame_blk) + 9'(frame_cpl)) != ComplTarget || frame_sum != b) begin
      return 1'b1;
    end
    if (accepted_bytes > CountMax - 17'(PayloadLen)) begin
      accepted_bytes = CountMax;
    end else begin
      accepted_bytes = accepted_bytes + 17'(PayloadLen);
    end
    if (accepted_bytes < area_bytes) begin
      r.kind = KindAck;
    end
    return 1'b1;
  endfunction

  // Offers one byte, starting just after a falling edge, and returns just
  // after the falling edge that follows its transaction. Valid is left high
  // so that the next byte can follow without a gap.
  task automatic send_line_byte(input logic [7:0] b, input bit typed,
                                input rx_result_t typed_res);
    rx_result_t predicted;
    bit         has_result;
    while ($urandom_range(99) < idle_pct) begin
      line_if.valid = 1'b0;
      @(negedge clk_i);
    end
    line_if.valid     = 1'b1;
    line_if.line_byte = b;
    do @(posedge clk_i); while (!line_if.ready);
    has_result = receiver_next_result(b, predicted);
    if (typed) begin
      awaited_results.push_back(typed_res);
    end else if (has_result) begin
      awaited_results.push_back(predicted);
    end
    line_bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] blk, input logic [7:0] cpl,
                            input logic [7:0] payload [PayloadLen],
                            input logic [7:0] sum_err, input bit typed,
                            input rx_result_t typed_res);
    logic [7:0] sum;
    sum = 8'h00;
    send_line_byte(ByteSoh, 1'b0, '0);
    send_line_byte(blk, 1'b0, '0);
    send_line_byte(cpl, 1'b0, '0);
    foreach (payload[i]) begin
      sum = sum + payload[i];
      send_line_byte(payload[i], 1'b0, '0);
    end
    send_line_byte(sum + sum_err, typed, typed_res);
  endtask

  // Mostly uniform bytes, with the extremes and the framing values favored.
  function automatic logic [7:0] random_line_byte();
    case ($urandom_range(15))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return ByteSoh;
      3:       return ByteEot;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Sends one random piece of traffic. Most pieces are well-formed frames
  // with random content.
  task automatic send_random_piece();
    logic [7:0]  payload [PayloadLen];
    logic [7:0]  blk;
    int unsigned pick;
    pick = $urandom_range(99);
    blk  = 8'($urandom_range(255));
    foreach (payload[i]) payload[i] = random_line_byte();
    if (pick < 60) begin
      send_frame(blk, ~blk, payload, 8'h00, 1'b0, '0);
    end else if (pick < 68) begin
      send_frame(blk, ~blk ^ 8'($urandom_range(1, 255)), payload, 8'h00, 1'b0, '0);
    end else if (pick < 76) begin
      send_frame(blk, ~blk, payload, 8'($urandom_range(1, 255)), 1'b0, '0);
    end else if (pick < 84) begin
      send_line_byte(ByteEot, 1'b0, '0);
    end else if (pick < 92) begin
      send_line_byte(random_line_byte(), 1'b0, '0);
    end else begin
      // A cut-off frame: the receiver has no timeout, so the bytes that
      // follow are taken as the rest of this frame.
      send_line_byte(ByteSoh, 1'b0, '0);
      repeat ($urandom_range(1, 40)) send_line_byte(random_line_byte(), 1'b0, '0);
    end
  endtask

  // Drops valid, waits until every awaited result has arrived, and then lets the
  // receiver run on idle, since the bytes of a frame header cause no result.
  task automatic settle();
    line_if.valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_area_size(input logic [16:0] size);
    cfg_we_i   = 1'b1;
    cfg_data_i = size;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    area_bytes = size;
  endtask

  // Random traffic for about the given number of bytes, then filler bytes
  // until the receiver is back between frames, so that the next register
  // write finds it idle.
  task automatic run_mixed_traffic(input int unsigned budget);
    int unsigned stop_at;
    stop_at = line_bytes_sent + budget;
    while (line_bytes_sent < stop_at) send_random_piece();
    while (frame_pos != 0) send_line_byte(random_line_byte(), 1'b0, '0);
    settle();
  endtask

  // Result sink: stalls at random on each falling edge.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready = ($urandom_range(99) >= idle_pct);
    end
  end

  // Every result transaction is compared with the oldest awaited result.
  always @(posedge clk_i) begin
    rx_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result_kind: expected no result, actual %0d", res_if.result_kind);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (res_if.result_kind !== want.kind) begin
          $error("result_kind: expected %0d, actual %0d", want.kind, res_if.result_kind);
          mismatch_count++;
        end
        if (res_if.write_offset !== want.offset) begin
          $error("write_offset: expected %0d, actual %0d", want.offset,
                 res_if.write_offset);
          mismatch_count++;
        end
        if (res_if.write_byte !== want.data) begin
          $error("write_byte: expected %0d, actual %0d", want.data, res_if.write_byte);
          mismatch_count++;
        end
        if (res_if.session_total !== want.total) begin
          $error("session_total: expected %0d, actual %0d", want.total,
                 res_if.session_total);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    dir_row_t    row;
    rx_result_t  typed_res;
    logic [7:0]  payload [PayloadLen];

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_data_i        = '0;
    line_if.valid     = 1'b0;
    line_if.line_byte = 8'h00;
    idle_pct          = 0;
    mismatch_count    = 0;
    line_bytes_sent   = 0;
    frame_pos         = 0;
    frame_blk         = 8'h00;
    frame_cpl         = 8'h00;
    frame_sum         = 8'h00;
    accepted_bytes    = '0;
    saved_total       = '0;
    area_bytes        = AreaReset;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows with the area size left at its reset value. They run
    // with no idling on either side, so frames go through back to back.
    for (int r = 0; r < DirRows; r++) begin
      row       = dir_table[r];
      typed_res = '{kind: row.exp_kind, offset: 16'h0000, data: 8'h00,
                    total: row.exp_total};
      if (row.kind == RowByte) begin
        send_line_byte(row.lead, row.typed, typed_res);
      end else begin
        for (int i = 0; i < PayloadLen; i++) begin
          payload[i] = row.base + 8'(i) * row.step;
        end
        send_frame(row.lead, row.cpl, payload, row.sum_err, row.typed, typed_res);
      end
    end
    settle();

    // An area size of one block is reached by the first good block, so every
    // good block in the session is answered with NAK.
    idle_pct = 16;
    write_area_size(17'd128);
    run_mixed_traffic(120);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("xmodem_block_receiver_top_tb passed");
    end else begin
      $display("xmodem_block_receiver_top_tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/xbr_pkg.sv
hw/rtl/xbr_byte_if.sv
hw/rtl/xbr_result_if.sv
hw/rtl/xbr_frame.sv
hw/rtl/xmodem_block_receiver_top.sv
hw/rtl/xbr_checker.sv
tb/xmodem_block_receiver_top_tb.sv
